@@ hdl/css_pkg.sv @@
// ----------------------------------------------------------------------------
// css_pkg
// shared types and constants of the channel scan scheduler
// ----------------------------------------------------------------------------
package css_pkg;

   localparam int MAX_CHANNELS = 7;
   localparam int PHASE_W      = 4;
   localparam int CHAN_W       = 3;
   localparam int PERIOD_W     = 16;
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;

   localparam logic [CHAN_W-1:0]   NO_CHANNEL   = 3'd7;
   localparam logic [PHASE_W-1:0]  PERIOD_PHASE = 4'd8;
   localparam logic [PERIOD_W-1:0] SECOND_PERIOD_RESET = 16'd600;
   localparam logic [PERIOD_W-1:0] TIMEOUT_RESET       = 16'd255;

   typedef enum logic [1:0] {
      REQ_CLOCK = 2'd0,
      REQ_TICK  = 2'd1,
      REQ_CLEAR = 2'd2,
      REQ_ACK   = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      REG_ENABLE_MASK    = 3'd0,
      REG_FIRST_PERIOD   = 3'd1,
      REG_SECOND_PERIOD  = 3'd2,
      REG_FIRST_ENABLE   = 3'd3,
      REG_SECOND_ENABLE  = 3'd4,
      REG_CLOCK_TIMEOUT  = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [CHAN_W-1:0] channel;
      logic              period_select;
   } req_item_type;

   typedef struct packed {
      logic [MAX_CHANNELS-1:0] pending_mask;
      logic [CHAN_W-1:0]       next_channel;
      logic                    first_due;
      logic                    second_due;
      logic                    clock_fail;
      logic [PHASE_W-1:0]      phase;
   } rsp_item_type;

   typedef struct packed {
      logic [MAX_CHANNELS-1:0] channel_enable_mask;
      logic [PERIOD_W-1:0]     first_period;
      logic [PERIOD_W-1:0]     second_period;
      logic                    first_period_enable;
      logic                    second_period_enable;
      logic [PERIOD_W-1:0]     clock_timeout;
   } cfg_type;

endpackage

@@ hdl/css_regs.sv @@
// ----------------------------------------------------------------------------
// css_regs
// configuration registers behind the apb-style port
// ----------------------------------------------------------------------------
module css_regs #(
   parameter int NUM_CHANNELS = 7
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [css_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [css_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [css_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready,
   output css_pkg::cfg_type                    cfg
);

   localparam logic [css_pkg::MAX_CHANNELS-1:0] CHAN_MASK =
      css_pkg::MAX_CHANNELS'((1 << NUM_CHANNELS) - 1);

   css_pkg::cfg_type      cfg_ff;
   css_pkg::cfg_type      cfg_in;
   css_pkg::reg_index_type reg_index;
   logic                  write_en;

   assign reg_index = css_pkg::reg_index_type'(paddr[css_pkg::CSR_ADDR_W-1:2]);
   assign write_en  = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_index)
            css_pkg::REG_ENABLE_MASK:
               cfg_in.channel_enable_mask = pwdata[css_pkg::MAX_CHANNELS-1:0] & CHAN_MASK;
            css_pkg::REG_FIRST_PERIOD:  cfg_in.first_period  = pwdata[css_pkg::PERIOD_W-1:0];
            css_pkg::REG_SECOND_PERIOD: cfg_in.second_period = pwdata[css_pkg::PERIOD_W-1:0];
            css_pkg::REG_FIRST_ENABLE:  cfg_in.first_period_enable  = pwdata[0];
            css_pkg::REG_SECOND_ENABLE: cfg_in.second_period_enable = pwdata[0];
            css_pkg::REG_CLOCK_TIMEOUT: cfg_in.clock_timeout = pwdata[css_pkg::PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_index)
         css_pkg::REG_ENABLE_MASK:
            prdata = css_pkg::CSR_DATA_W'(cfg_ff.channel_enable_mask);
         css_pkg::REG_FIRST_PERIOD:  prdata = css_pkg::CSR_DATA_W'(cfg_ff.first_period);
         css_pkg::REG_SECOND_PERIOD: prdata = css_pkg::CSR_DATA_W'(cfg_ff.second_period);
         css_pkg::REG_FIRST_ENABLE:
            prdata = css_pkg::CSR_DATA_W'(cfg_ff.first_period_enable);
         css_pkg::REG_SECOND_ENABLE:
            prdata = css_pkg::CSR_DATA_W'(cfg_ff.second_period_enable);
         css_pkg::REG_CLOCK_TIMEOUT: prdata = css_pkg::CSR_DATA_W'(cfg_ff.clock_timeout);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_enable_mask  <= '0;
         cfg_ff.first_period         <= '0;
         cfg_ff.second_period        <= css_pkg::SECOND_PERIOD_RESET;
         cfg_ff.first_period_enable  <= 1'b0;
         cfg_ff.second_period_enable <= 1'b1;
         cfg_ff.clock_timeout        <= css_pkg::TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hdl/css_core.sv @@
// ----------------------------------------------------------------------------
// css_core
// scheduler state and its update for one request
// ----------------------------------------------------------------------------
module css_core #(
   parameter int NUM_CHANNELS = 7,
   parameter int COUNT_BITS   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  update,
   input  css_pkg::req_item_type item,
   input  css_pkg::cfg_type      cfg,
   output css_pkg::rsp_item_type result
);

   localparam int CMP_W = (COUNT_BITS > css_pkg::PERIOD_W) ? COUNT_BITS : css_pkg::PERIOD_W;
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   logic [css_pkg::PHASE_W-1:0]      phase_ff,   phase_in;
   logic [css_pkg::MAX_CHANNELS-1:0] pending_ff, pending_in;
   logic [COUNT_BITS-1:0]            first_count_ff,  first_count_in;
   logic [COUNT_BITS-1:0]            second_count_ff, second_count_in;
   logic                             first_flag_ff,   first_flag_in;
   logic                             second_flag_ff,  second_flag_in;
   logic [COUNT_BITS-1:0]            wait_count_ff,   wait_count_in;
   logic                             fail_ff,         fail_in;

   logic [css_pkg::PHASE_W-1:0] phase_step;
   logic [COUNT_BITS-1:0]       first_step;
   logic [COUNT_BITS-1:0]       second_step;
   logic [css_pkg::CHAN_W-1:0]  lowest;

   assign phase_step  = phase_ff + 4'd1;
   assign first_step  = first_count_ff + COUNT_ONE;
   assign second_step = second_count_ff + COUNT_ONE;

   always_comb begin
      phase_in        = phase_ff;
      pending_in      = pending_ff;
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      first_flag_in   = first_flag_ff;
      second_flag_in  = second_flag_ff;
      wait_count_in   = wait_count_ff;
      fail_in         = fail_ff;
      case (css_pkg::req_kind_type'(item.req_type))
         css_pkg::REQ_CLOCK: begin
            // phase codes past the period phase fall back to zero as well
            if (phase_step < css_pkg::PERIOD_PHASE) begin
               phase_in = phase_step;
            end else begin
               phase_in = '0;
            end
            for (int i = 0; i < NUM_CHANNELS; i++) begin
               if (phase_step == css_pkg::PHASE_W'(i + 1)) begin
                  pending_in[i] = cfg.channel_enable_mask[i];
               end
            end
            if (phase_step == css_pkg::PERIOD_PHASE) begin
               first_count_in  = first_step;
               second_count_in = second_step;
               if (first_step == COUNT_BITS'(cfg.first_period)) begin
                  first_flag_in  = 1'b1;
                  first_count_in = '0;
               end
               if (second_step == COUNT_BITS'(cfg.second_period)) begin
                  second_flag_in  = 1'b1;
                  second_count_in = '0;
               end
            end
            wait_count_in = '0;
            fail_in       = 1'b0;
         end
         css_pkg::REQ_TICK: begin
            if (CMP_W'(wait_count_ff) > CMP_W'(cfg.clock_timeout)) begin
               fail_in       = 1'b1;
               wait_count_in = '0;
            end else begin
               wait_count_in = wait_count_ff + COUNT_ONE;
            end
         end
         css_pkg::REQ_CLEAR: begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
               if (item.channel == css_pkg::CHAN_W'(i)) begin
                  pending_in[i] = 1'b0;
               end
            end
         end
         default: begin
            if (item.period_select) begin
               second_flag_in = 1'b0;
            end else begin
               first_flag_in = 1'b0;
            end
         end
      endcase
   end

   // lowest pending channel
   always_comb begin
      lowest = css_pkg::NO_CHANNEL;
      for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
         if (pending_in[i]) begin
            lowest = css_pkg::CHAN_W'(i);
         end
      end
   end

   always_comb begin
      result.pending_mask = pending_in;
      result.next_channel = lowest;
      result.first_due    = first_flag_in & cfg.first_period_enable;
      result.second_due   = second_flag_in & cfg.second_period_enable;
      result.clock_fail   = fail_in;
      result.phase        = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= '0;
         pending_ff      <= '0;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         first_flag_ff   <= 1'b0;
         second_flag_ff  <= 1'b0;
         wait_count_ff   <= '0;
         fail_ff         <= 1'b0;
      end else if (update) begin
         phase_ff        <= phase_in;
         pending_ff      <= pending_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         first_flag_ff   <= first_flag_in;
         second_flag_ff  <= second_flag_in;
         wait_count_ff   <= wait_count_in;
         fail_ff         <= fail_in;
      end
   end

endmodule

@@ hdl/channel_scan_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// channel_scan_scheduler_top
// sampling-clock scheduler for a multi-channel sensor scan
// ----------------------------------------------------------------------------
// requests arrive on the req_ channel: clock pulse, timer tick, channel clear
// or period acknowledge. every request gives exactly one status transfer on
// the rsp_ channel with the pending mask, lowest pending channel, period due
// flags, clock failure flag and scan phase after that request.
// a request is taken into an input register, then the state update and the
// status word are computed combinationally and captured in the output register.
// status valid rises once the request has passed the input register and the
// output register; throughput is one request per cycle while the receiver
// does not stall.
// while the receiver stalls the held status stays put, the input register
// still takes one more request, and then req_ready drops.
// the apb-style port writes and reads the six configuration registers at
// byte addresses 0 to 20; pready is always high.
// synchronous reset clears all scheduler state and both valid bits and loads
// the register defaults (second period 600, second enable on, timeout 255).
// ----------------------------------------------------------------------------
module channel_scan_scheduler_top #(
   parameter int NUM_CHANNELS = 7,
   parameter int COUNT_BITS   = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  css_pkg::req_item_type           req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output css_pkg::rsp_item_type           rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [css_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [css_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [css_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);

   logic                  in_valid_ff,  in_valid_in;
   css_pkg::req_item_type in_data_ff,   in_data_in;
   logic                  out_valid_ff, out_valid_in;
   css_pkg::rsp_item_type out_data_ff,  out_data_in;

   logic                  advance;
   logic                  req_fire;
   css_pkg::cfg_type      cfg;
   css_pkg::rsp_item_type result;

   css_regs #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   css_core #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .COUNT_BITS   (COUNT_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .update (advance),
      .item   (in_data_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_data_in  = result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

endmodule

@@ hdl/css_checker.sv @@
// ----------------------------------------------------------------------------
// css_checker
// port-level checks of the channel scan scheduler status stream
// ----------------------------------------------------------------------------
module css_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input css_pkg::rsp_item_type rsp_data
);

   // a stalled status transfer holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("status changed while stalled");

   // next channel agrees with the pending mask
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.pending_mask == '0) ==
                     (rsp_data.next_channel == css_pkg::NO_CHANNEL)))
      else $error("next channel does not match pending mask");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.next_channel != css_pkg::NO_CHANNEL |->
         rsp_data.pending_mask[rsp_data.next_channel] &&
         ((rsp_data.pending_mask &
           ((css_pkg::MAX_CHANNELS'(1) << rsp_data.next_channel) -
            css_pkg::MAX_CHANNELS'(1))) == '0))
      else $error("next channel is not the lowest pending one");

   // the phase never shows the period phase itself
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.phase < css_pkg::PERIOD_PHASE)
      else $error("scan phase out of range");

   // no status right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("status valid after reset");

endmodule

bind channel_scan_scheduler_top css_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the channel scan scheduler
// ----------------------------------------------------------------------------
// requests go in on the req_ channel and every one gives one status
// transfer. each accepted request runs through a local scheduler model
// that keeps its own scan phase, pending bits, frame counters and watchdog,
// and the status it predicts is queued and matched field by field against
// the rsp_ channel. registers go through the apb-style port, only while
// nothing is in flight, and are read back after each write. tests: directed
// corner cases, zero period, watchdog at maximum timeout, random
// rounds under several register settings, and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;

   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int SETTLE       = 8;
   localparam int SHOW_LIMIT   = 10;
   localparam int ROUNDS       = 7;
   localparam int ROUND_ITEMS  = 80;
   localparam int FRAME_PULSES = 8;
   localparam int WRAP_FRAMES  = 8;
   localparam int MAX_TICKS    = 32;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   css_pkg::req_item_type          req_data;
   logic                           rsp_valid;
   logic                           rsp_ready;
   css_pkg::rsp_item_type          rsp_data;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [css_pkg::CSR_ADDR_W-1:0] paddr;
   logic [css_pkg::CSR_DATA_W-1:0] pwdata;
   logic [css_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   // register shadow and scheduler model state
   css_pkg::cfg_type                 cfg;
   logic [css_pkg::PHASE_W-1:0]      phase_now;
   logic [css_pkg::MAX_CHANNELS-1:0] pending_now;
   logic [css_pkg::PERIOD_W-1:0]     first_frames;
   logic [css_pkg::PERIOD_W-1:0]     second_frames;
   logic                             first_hit;
   logic                             second_hit;
   logic [css_pkg::PERIOD_W-1:0]     tick_count;
   logic                             clock_lost;

   css_pkg::rsp_item_type status_q[$];

   int  mismatches  = 0;
   int  requests    = 0;
   int  transfers   = 0;
   int  fail_seen   = 0;
   int  due_seen    = 0;
   int  cycles      = 0;
   int  hold_left   = 0;
   bit  idle_on     = 1'b1;

   channel_scan_scheduler_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d status transfers outstanding",
                  cycles, status_q.size());
         $display("FAILURE");
         $finish;
      end
   end

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= SHOW_LIMIT)
            $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, name, want, got);
      end
   endtask

   // model of one request; updates the local state and returns the status
   function automatic css_pkg::rsp_item_type predict_status(css_pkg::req_item_type item);
      css_pkg::rsp_item_type       status;
      logic [css_pkg::PHASE_W-1:0] step;
      int                          k;
      step = phase_now + 1'b1;
      case (css_pkg::req_kind_type'(item.req_type))
         css_pkg::REQ_CLOCK: begin
            if (step != '0 && step < css_pkg::PERIOD_PHASE) begin
               k = int'(step) - 1;
               if (k < css_pkg::MAX_CHANNELS)
                  pending_now[k] = cfg.channel_enable_mask[k];
               phase_now = step;
            end else begin
               if (step == css_pkg::PERIOD_PHASE) begin
                  first_frames = first_frames + 1'b1;
                  if (first_frames == cfg.first_period) begin
                     first_hit    = 1'b1;
                     first_frames = '0;
                  end
                  second_frames = second_frames + 1'b1;
                  if (second_frames == cfg.second_period) begin
                     second_hit    = 1'b1;
                     second_frames = '0;
                  end
               end
               phase_now = '0;
            end
            tick_count = '0;
            clock_lost = 1'b0;
         end
         css_pkg::REQ_TICK: begin
            if (tick_count > cfg.clock_timeout) begin
               clock_lost = 1'b1;
               tick_count = '0;
            end else begin
               tick_count = tick_count + 1'b1;
            end
         end
         css_pkg::REQ_CLEAR: begin
            if (item.channel < css_pkg::MAX_CHANNELS)
               pending_now[item.channel] = 1'b0;
         end
         default: begin
            if (item.period_select)
               second_hit = 1'b0;
            else
               first_hit = 1'b0;
         end
      endcase
      status.pending_mask = pending_now;
      status.next_channel = css_pkg::NO_CHANNEL;
      for (k = css_pkg::MAX_CHANNELS - 1; k >= 0; k--)
         if (pending_now[k])
            status.next_channel = k[css_pkg::CHAN_W-1:0];
      status.first_due  = first_hit & cfg.first_period_enable;
      status.second_due = second_hit & cfg.second_period_enable;
      status.clock_fail = clock_lost;
      status.phase      = phase_now;
      return status;
   endfunction

   // request prediction and status checking, both at the rising edge
   always @(posedge clock) begin : status_check
      css_pkg::rsp_item_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            status_q.push_back(predict_status(req_data));
            requests++;
         end
         if (rsp_valid && rsp_ready) begin
            transfers++;
            if (rsp_data.clock_fail)
               fail_seen++;
            if (rsp_data.first_due || rsp_data.second_due)
               due_seen++;
            if (status_q.size() == 0) begin
               mismatches++;
               if (mismatches <= SHOW_LIMIT)
                  $display("%0t status transfer with none expected: %h", $realtime, rsp_data);
            end else begin
               want = status_q.pop_front();
               check_field("pending_mask", want.pending_mask, rsp_data.pending_mask);
               check_field("next_channel", want.next_channel, rsp_data.next_channel);
               check_field("first_due",    want.first_due,    rsp_data.first_due);
               check_field("second_due",   want.second_due,   rsp_data.second_due);
               check_field("clock_fail",   want.clock_fail,   rsp_data.clock_fail);
               check_field("phase",        want.phase,        rsp_data.phase);
            end
         end
      end
   end

   // receiver: random stalls, optional hold-off counted here
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= !idle_on || ($urandom_range(99) >= 36);
         end
      end
   end

   task automatic send_request(css_pkg::req_item_type item);
      @(negedge clock);
      while (idle_on && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_kind(css_pkg::req_kind_type kind, int unsigned chan, bit sel);
      css_pkg::req_item_type item;
      item.req_type      = kind;
      item.channel       = chan[css_pkg::CHAN_W-1:0];
      item.period_select = sel;
      send_request(item);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (status_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // apb write with random upper bits, then read back
   task automatic write_reg(css_pkg::reg_index_type idx, int unsigned field);
      int unsigned width;
      logic [css_pkg::CSR_DATA_W-1:0] keep;
      logic [css_pkg::CSR_DATA_W-1:0] value;
      case (idx) inside
         css_pkg::REG_ENABLE_MASK:  width = css_pkg::MAX_CHANNELS;
         css_pkg::REG_FIRST_ENABLE,
         css_pkg::REG_SECOND_ENABLE: width = 1;
         default:                    width = css_pkg::PERIOD_W;
      endcase
      keep  = (css_pkg::CSR_DATA_W'(1) << width) - 1;
      value = (field & keep) | ($urandom & ~keep);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= css_pkg::CSR_ADDR_W'(int'(idx) * 4);
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         css_pkg::REG_ENABLE_MASK:
            cfg.channel_enable_mask = value[css_pkg::MAX_CHANNELS-1:0];
         css_pkg::REG_FIRST_PERIOD:  cfg.first_period  = value[css_pkg::PERIOD_W-1:0];
         css_pkg::REG_SECOND_PERIOD: cfg.second_period = value[css_pkg::PERIOD_W-1:0];
         css_pkg::REG_FIRST_ENABLE:  cfg.first_period_enable  = value[0];
         css_pkg::REG_SECOND_ENABLE: cfg.second_period_enable = value[0];
         default:                    cfg.clock_timeout = value[css_pkg::PERIOD_W-1:0];
      endcase
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      check_field("register readback", value & keep, prdata & keep);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic write_all(int unsigned mask, int unsigned first_p, int unsigned second_p,
                            bit first_en, bit second_en, int unsigned timeout);
      write_reg(css_pkg::REG_ENABLE_MASK, mask);
      write_reg(css_pkg::REG_FIRST_PERIOD, first_p);
      write_reg(css_pkg::REG_SECOND_PERIOD, second_p);
      write_reg(css_pkg::REG_FIRST_ENABLE, first_en);
      write_reg(css_pkg::REG_SECOND_ENABLE, second_en);
      write_reg(css_pkg::REG_CLOCK_TIMEOUT, timeout);
   endtask

   function automatic css_pkg::req_item_type random_request(int unsigned tick_pct);
      css_pkg::req_item_type item;
      int unsigned           roll;
      roll               = $urandom_range(99);
      item.channel       = css_pkg::CHAN_W'($urandom_range(7));
      item.period_select = 1'($urandom_range(1));
      if (roll < tick_pct)
         item.req_type = css_pkg::REQ_TICK;
      else if (roll < tick_pct + 40)
         item.req_type = css_pkg::REQ_CLOCK;
      else if (roll < 90)
         item.req_type = css_pkg::REQ_CLEAR;
      else
         item.req_type = css_pkg::REQ_ACK;
      return item;
   endfunction

   // one full scan, clears walking up, acks, watchdog trip and recovery
   task automatic test_directed();
      int unsigned chan;
      write_all(127, 1, 2, 1'b1, 1'b1, 0);
      repeat (FRAME_PULSES) send_kind(css_pkg::REQ_CLOCK, 0, 1'b0);
      send_kind(css_pkg::REQ_CLEAR, css_pkg::NO_CHANNEL, 1'b1);
      for (chan = 0; chan < css_pkg::MAX_CHANNELS; chan++)
         send_kind(css_pkg::REQ_CLEAR, chan, chan[0]);
      send_kind(css_pkg::REQ_ACK, css_pkg::NO_CHANNEL, 1'b0);
      send_kind(css_pkg::REQ_ACK, 0, 1'b1);
      send_kind(css_pkg::REQ_TICK, 5, 1'b1);
      send_kind(css_pkg::REQ_TICK, 2, 1'b0);
      send_kind(css_pkg::REQ_CLOCK, 7, 1'b1);
      wait_drained();
   endtask

   // zero period stays quiet until the frame counter wraps
   task automatic test_period_wrap();
      write_all($urandom_range(127), 0, 0, 1'b1, 1'b1, 255);
      idle_on = 1'b0;
      repeat (WRAP_FRAMES * FRAME_PULSES) send_kind(css_pkg::REQ_CLOCK, 0, 1'b0);
      wait_drained();
      idle_on = 1'b1;
   endtask

   // maximum timeout never trips the watchdog
   task automatic test_watchdog_max();
      write_reg(css_pkg::REG_CLOCK_TIMEOUT, (1 << css_pkg::PERIOD_W) - 1);
      idle_on = 1'b0;
      send_kind(css_pkg::REQ_CLOCK, 0, 1'b0);
      repeat (MAX_TICKS) send_kind(css_pkg::REQ_TICK, 0, 1'b0);
      send_kind(css_pkg::REQ_CLOCK, 0, 1'b0);
      wait_drained();
      idle_on = 1'b1;
   endtask

   task automatic test_random();
      int          round;
      int unsigned tick_pct;
      for (round = 0; round < ROUNDS; round++) begin
         if (round == 0)
            write_all(127, 1, 1, 1'b1, 1'b1, 0);
         else if (round == ROUNDS - 1)
            write_all(0, (1 << css_pkg::PERIOD_W) - 1, (1 << css_pkg::PERIOD_W) - 1,
                      1'b0, 1'b0, (1 << css_pkg::PERIOD_W) - 1);
         else
            write_all($urandom_range(127), $urandom_range(4), $urandom_range(1, 4),
                      1'($urandom_range(1)), 1'($urandom_range(1)), $urandom_range(6));
         tick_pct = $urandom_range(15, 45);
         // one round runs with no gaps on either side
         idle_on  = (round != 3);
         repeat (ROUND_ITEMS) send_request(random_request(tick_pct));
         wait_drained();
      end
      idle_on = 1'b1;
   endtask

   // receiver holds off long enough for req_ready to drop
   task automatic test_backpressure();
      write_all($urandom_range(127), 2, 3, 1'b1, 1'b1, 3);
      hold_left = 150;
      repeat (24) send_request(random_request(30));
      wait_drained();
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      cfg                      = '0;
      cfg.second_period        = css_pkg::SECOND_PERIOD_RESET;
      cfg.second_period_enable = 1'b1;
      cfg.clock_timeout        = css_pkg::TIMEOUT_RESET;
      phase_now     = '0;
      pending_now   = '0;
      first_frames  = '0;
      second_frames = '0;
      first_hit     = 1'b0;
      second_hit    = 1'b0;
      tick_count    = '0;
      clock_lost    = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_period_wrap();
      test_watchdog_max();
      test_random();
      test_backpressure();
      wait_drained();

      $display("run covered %0d requests and %0d status transfers over %0d cycles",
               requests, transfers, cycles);
      $display("statuses with a period due: %0d, with clock failure: %0d, mismatches: %0d",
               due_seen, fail_seen, mismatches);
      if (mismatches == 0 && status_q.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
